[rtl/core/urbfg_pkg.sv]
package urbfg_pkg;

    // Event opcodes
    localparam logic [2:0] OP_HOST_PUT  = 3'd0;
    localparam logic [2:0] OP_HOST_GET  = 3'd1;
    localparam logic [2:0] OP_LINE_RDY  = 3'd2;
    localparam logic [2:0] OP_LINE_BYTE = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;
    localparam logic [2:0] OP_CLR_FRAME = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TX_FULL  = 2'd1;
    localparam logic [1:0] ST_RX_EMPTY = 2'd2;
    localparam logic [1:0] ST_TX_EMPTY = 2'd3;

    // Source of the result byte
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_TX   = 2'd1;
    localparam logic [1:0] SRC_RX   = 2'd2;

    // Configuration register map
    localparam int         CFG_IDX_W       = 4;
    localparam logic [3:0] CFG_HALF_DUPLEX = 4'd0;
    localparam logic [3:0] CFG_FRAME_GAP   = 4'd1;

    localparam logic       HALF_DUPLEX_RST = 1'b1;
    localparam logic [7:0] FRAME_GAP_RST   = 8'd10;

    localparam int LEVEL_W = 7;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

[rtl/core/urbfg_in_if.sv]
interface urbfg_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

[rtl/core/urbfg_out_if.sv]
interface urbfg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       line_send;
    logic       tx_busy;
    logic       frame_ready;
    logic [6:0] rx_level;
    logic [6:0] tx_level;

    modport source (
        output valid, output out_byte, output status, output line_send,
        output tx_busy, output frame_ready, output rx_level, output tx_level,
        input ready
    );
    modport sink (
        input valid, input out_byte, input status, input line_send,
        input tx_busy, input frame_ready, input rx_level, input tx_level,
        output ready
    );
endinterface

[rtl/core/urbfg_cfg_if.sv]
interface urbfg_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/urbfg_fifo.sv]
module urbfg_fifo
    import urbfg_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_fifo_cmd          i_cmd,
    input  logic [7:0]         i_wdata,
    output t_fifo_stat         o_stat,
    output logic [LEVEL_W-1:0] o_level,
    output logic [7:0]         o_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]          r_mem [DEPTH];
    logic [7:0]          r_rdata;
    logic [PW-1:0]       r_head;
    logic [PW-1:0]       r_tail;
    logic [CW-1:0]       r_count;
    logic [PW-1:0]       n_head;
    logic [PW-1:0]       n_tail;
    logic [CW-1:0]       n_count;
    logic [CW+LEVEL_W-1:0] level_ext;

    // Pointer wrap and fill count
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.push) begin
            n_head  = (r_head == PW'(DEPTH - 1)) ? '0 : PW'(r_head + 1'b1);
            n_count = CW'(r_count + 1'b1);
        end
        if (i_cmd.pop) begin
            n_tail  = (r_tail == PW'(DEPTH - 1)) ? '0 : PW'(r_tail + 1'b1);
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_head] <= i_wdata;
        end
        if (i_cmd.pop) begin
            r_rdata <= r_mem[r_tail];
        end
    end

    assign level_ext    = {{LEVEL_W{1'b0}}, r_count};
    assign o_level      = level_ext[LEVEL_W-1:0];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rdata      = r_rdata;

endmodule

[rtl/core/uart_ring_buffers_with_frame_gap.sv]
// Latency: the result of an accepted event is valid on the next cycle.
// Throughput: one event per cycle unless output stalls; each event is at most one
// pointer or counter step; each FIFO has one write and one registered read port.
// Input ready drops only while a finished result waits on a stalled output.
// Reset (synchronous, active low) empties both FIFOs, clears the busy flag,
// gap timer and frame flag, and loads half duplex = 1, frame gap = 10.
module uart_ring_buffers_with_frame_gap
    import urbfg_pkg::*;
#(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    urbfg_in_if.sink    i_in,
    urbfg_out_if.source o_out,
    urbfg_cfg_if.sink   i_cfg
);

    logic               r_half_duplex;
    logic [7:0]         r_frame_gap;
    logic               r_busy;
    logic [7:0]         r_gap_timer;
    logic               r_frame;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic               r_send;
    logic [1:0]         r_src;

    logic               n_busy;
    logic [7:0]         n_gap_timer;
    logic               n_frame;
    logic [1:0]         n_status;
    logic               n_send;
    logic [1:0]         n_src;

    logic               in_ready;
    logic               accept;
    t_fifo_cmd          tx_cmd;
    t_fifo_cmd          rx_cmd;
    t_fifo_stat         tx_stat;
    t_fifo_stat         rx_stat;
    logic [LEVEL_W-1:0] tx_level;
    logic [LEVEL_W-1:0] rx_level;
    logic [7:0]         tx_rdata;
    logic [7:0]         rx_rdata;
    logic [7:0]         out_byte;

    assign in_ready   = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Event decode
    always_comb begin
        tx_cmd      = '0;
        rx_cmd      = '0;
        n_busy      = r_busy;
        n_gap_timer = r_gap_timer;
        n_frame     = r_frame;
        n_status    = ST_OK;
        n_send      = 1'b0;
        n_src       = SRC_NONE;
        case (i_in.opcode)
            OP_HOST_PUT: begin
                if (tx_stat.full) begin
                    n_status = ST_TX_FULL;
                end else begin
                    tx_cmd.push = accept;
                end
            end
            OP_HOST_GET: begin
                if (rx_stat.empty) begin
                    n_status = ST_RX_EMPTY;
                end else begin
                    rx_cmd.pop = accept;
                    n_src      = SRC_RX;
                end
            end
            OP_LINE_RDY: begin
                if (tx_stat.empty) begin
                    n_busy   = 1'b0;
                    n_status = ST_TX_EMPTY;
                end else begin
                    tx_cmd.pop = accept;
                    n_busy     = 1'b1;
                    n_send     = 1'b1;
                    n_src      = SRC_TX;
                end
            end
            OP_LINE_BYTE: begin
                // half duplex drops line bytes while transmitting
                if (!(r_half_duplex && r_busy)) begin
                    rx_cmd.push = accept && !rx_stat.full;
                    n_gap_timer = r_frame_gap;
                end
            end
            OP_TICK: begin
                if (r_gap_timer != '0) begin
                    n_gap_timer = r_gap_timer - 8'd1;
                    if (r_gap_timer == 8'd1) begin
                        n_frame = 1'b1;
                    end
                end
            end
            OP_CLR_FRAME: begin
                n_frame = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Event state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_gap_timer <= '0;
            r_frame     <= 1'b0;
            r_out_valid <= 1'b0;
            r_src       <= SRC_NONE;
        end else begin
            if (accept) begin
                r_busy      <= n_busy;
                r_gap_timer <= n_gap_timer;
                r_frame     <= n_frame;
                r_src       <= n_src;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_send   <= n_send;
        end
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_duplex <= HALF_DUPLEX_RST;
            r_frame_gap   <= FRAME_GAP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HALF_DUPLEX: r_half_duplex <= i_cfg.data[0];
                CFG_FRAME_GAP:   r_frame_gap   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    urbfg_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tx_cmd),
        .i_wdata (i_in.data_byte),
        .o_stat  (tx_stat),
        .o_level (tx_level),
        .o_rdata (tx_rdata)
    );

    urbfg_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rx_cmd),
        .i_wdata (i_in.data_byte),
        .o_stat  (rx_stat),
        .o_level (rx_level),
        .o_rdata (rx_rdata)
    );

    // Result byte comes from the registered FIFO read data
    always_comb begin
        case (r_src)
            SRC_TX:  out_byte = tx_rdata;
            SRC_RX:  out_byte = rx_rdata;
            default: out_byte = 8'd0;
        endcase
    end

    // State registers only move on accept, so they match the held result
    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = out_byte;
    assign o_out.status      = r_status;
    assign o_out.line_send   = r_send;
    assign o_out.tx_busy     = r_busy;
    assign o_out.frame_ready = r_frame;
    assign o_out.rx_level    = rx_level;
    assign o_out.tx_level    = tx_level;

endmodule

[rtl/core/urbfg_checker.sv]
module urbfg_checker
    import urbfg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_status,
    input logic       i_out_line_send,
    input logic       i_out_tx_busy,
    input logic [6:0] i_out_rx_level,
    input logic [6:0] i_out_tx_level
);

    // A stalled result stays on the port
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Every accepted event yields a result on the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted event gave no result");

    // A byte sent to the line leaves the transmitter busy, with an OK status
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_line_send |-> i_out_tx_busy && i_out_status == ST_OK)
        else $error("line beat without busy transmitter");

    // Empty transmit reply shows an idle, empty transmitter
    a_tx_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_TX_EMPTY |->
            !i_out_tx_busy && !i_out_line_send && i_out_tx_level == 7'd0)
        else $error("transmit empty status inconsistent");

    // Empty receive reply shows an empty receive FIFO
    a_rx_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_RX_EMPTY |-> i_out_rx_level == 7'd0)
        else $error("receive empty status with nonzero level");

endmodule

bind uart_ring_buffers_with_frame_gap urbfg_checker u_urbfg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_status    (o_out.status),
    .i_out_line_send (o_out.line_send),
    .i_out_tx_busy   (o_out.tx_busy),
    .i_out_rx_level  (o_out.rx_level),
    .i_out_tx_level  (o_out.tx_level)
);
